FILE: design/pls_pkg.sv
`timescale 1ns / 1ps

package pls_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int KIND_W     = 2;
	localparam int POS_W      = 5;
	localparam int DOUT_W     = 32;
	localparam int DIN_W      = 32;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 40;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

	typedef struct packed {
		logic load;
		logic exec;
	} pls_cmd_t;

	typedef struct packed {
		logic             out_valid;
		logic [CNT_W-1:0] count;
	} pls_stat_t;

endpackage

FILE: design/pls_ctrl.sv
`timescale 1ns / 1ps

module pls_ctrl import pls_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_ready,
	input  pls_stat_t stat,
	output logic      in_ready,
	output pls_cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_free;

	assign out_free = !stat.out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign cmd.load = in_ready && in_valid;
	assign cmd.exec = (state_q == ST_EXEC) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cmd.exec) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: design/pls_datapath.sv
`timescale 1ns / 1ps

module pls_datapath import pls_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pls_cmd_t              cmd,
	input  logic [KIND_W-1:0]     kind,
	input  logic [POS_W-1:0]      position,
	input  logic [DIN_W-1:0]      data_in,
	input  logic                  out_ready,
	output pls_stat_t             stat,
	output logic [DOUT_W-1:0]     data_out,
	output logic [CNT_W-1:0]      count,
	output logic                  empty_res,
	output logic                  full_res,
	output logic                  error
);

	logic [KIND_W-1:0]     kind_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] din_q;
	logic [CNT_W-1:0]      count_q;
	logic [DATA_WIDTH-1:0] entries_q [CAPACITY];

	logic                  out_valid_q;
	logic [DOUT_W-1:0]     out_data_q;
	logic [CNT_W-1:0]      out_count_q;
	logic                  out_empty_q;
	logic                  out_full_q;
	logic                  out_err_q;

	logic                  ins_ok;
	logic                  acc_ok;
	logic                  rm_ok;
	logic [CNT_W-1:0]      next_count;
	logic [DATA_WIDTH-1:0] rd_word;

	assign ins_ok = (kind_q == KIND_INSERT) && (count_q < CNT_W'(CAPACITY))
		&& (pos_q <= count_q);
	assign acc_ok = ((kind_q == KIND_READ) || (kind_q == KIND_REMOVE)) && (pos_q < count_q);
	assign rm_ok  = acc_ok && (kind_q == KIND_REMOVE);
	assign rd_word = entries_q[pos_q[IDX_W-1:0]];

	always_comb begin
		next_count = count_q;
		if (ins_ok) next_count = count_q + CNT_W'(1);
		else if (rm_ok) next_count = count_q - CNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			pos_q  <= position;
			din_q  <= data_in[DATA_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (ins_ok) begin
					if (CNT_W'(i) == pos_q) begin
						entries_q[i] <= din_q;
					end else if (CNT_W'(i) > pos_q && i > 0) begin
						entries_q[i] <= entries_q[(i > 0) ? i - 1 : 0];
					end
				end else if (rm_ok) begin
					if (CNT_W'(i) >= pos_q && i < CAPACITY - 1) begin
						entries_q[i] <= entries_q[(i < CAPACITY - 1) ? i + 1 : i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				count_q     <= next_count;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_data_q  <= acc_ok ? DOUT_W'(rd_word) : '0;
			out_count_q <= next_count;
			out_empty_q <= (next_count == '0);
			out_full_q  <= (next_count == CNT_W'(CAPACITY));
			out_err_q   <= !(ins_ok || acc_ok);
		end
	end

	assign stat.out_valid = out_valid_q;
	assign stat.count     = count_q;
	assign data_out       = out_data_q;
	assign count          = out_count_q;
	assign empty_res      = out_empty_q;
	assign full_res       = out_full_q;
	assign error          = out_err_q;

endmodule

FILE: design/positional_list_store_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                    Contents
// s_axis    in   tvalid tready tdata tuser  one operation: kind, position, data_in
// m_axis    out  tvalid tready tdata        one result: data_out, count, flags
//
// Each beat is first captured into the input registers and then executed on the
// register file, where the whole entry row shifts together in one step.
// A result waits in the output register, and execution holds while it is not taken.
// Reset empties the list at once; entry contents are not cleared.
// The input is ready only while no beat is in execution.

module positional_list_store_core import pls_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // position[4:0], data_in[36:5], zero[39:37]
	input  logic [KIND_W-1:0]    s_tuser,  // kind[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // data_out[31:0], count[36:32], empty_res[37],
	                                       // full_res[38], error[39]
);

	pls_cmd_t          cmd;
	pls_stat_t         stat;
	logic [DOUT_W-1:0] data_out;
	logic [CNT_W-1:0]  count;
	logic              empty_res;
	logic              full_res;
	logic              error;

	pls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.in_ready  (s_tready),
		.cmd       (cmd)
	);

	pls_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.kind      (s_tuser),
		.position  (s_tdata[POS_W-1:0]),
		.data_in   (s_tdata[POS_W+DIN_W-1:POS_W]),
		.out_ready (m_tready),
		.stat      (stat),
		.data_out  (data_out),
		.count     (count),
		.empty_res (empty_res),
		.full_res  (full_res),
		.error     (error)
	);

	assign m_tvalid = stat.out_valid;
	assign m_tdata  = {error, full_res, empty_res, count, data_out};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second beat accepted during execution");

	a_err_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && error) |-> (data_out == '0))
		else $error("refused operation returned data");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (empty_res == (count == '0)))
		else $error("empty flag disagrees with count");

	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (m_tvalid && (count == stat.count)))
		else $error("result not presented after execution");

endmodule

FILE: bench/positional_list_store_core_test.sv
`timescale 1ns / 1ps

module positional_list_store_core_test;
	import pls_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 150;

	typedef struct packed {
		logic              error;
		logic              full;
		logic              empty;
		logic [CNT_W-1:0]  count;
		logic [DOUT_W-1:0] data;
	} list_result_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [KIND_W-1:0]    s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	logic [DATA_WIDTH-1:0] list_words [CAPACITY];
	int                    list_len = 0;
	list_result_t          result_q [$];

	bit idle_on     = 1'b1;
	bit rx_long_req = 1'b0;
	bit grow        = 1'b1;
	int rx_wait      = 0;
	int quiet_cycles = 0;
	int mismatches   = 0;
	int n_checked    = 0;
	int n_insert     = 0;
	int n_read       = 0;
	int n_remove     = 0;
	int n_refused    = 0;
	int n_full_seen  = 0;
	int n_empty_seen = 0;

	positional_list_store_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic list_result_t apply_list_op(logic [KIND_W-1:0] kind, int pos,
			logic [DIN_W-1:0] din);
		list_result_t res;
		res = '0;
		case (kind)
		KIND_INSERT: begin
			if (list_len >= CAPACITY || pos > list_len) begin
				res.error = 1'b1;
			end else begin
				for (int i = list_len; i > pos; i--)
					list_words[i] = list_words[i - 1];
				list_words[pos] = din[DATA_WIDTH-1:0];
				list_len++;
			end
		end
		KIND_READ, KIND_REMOVE: begin
			if (pos >= list_len) begin
				res.error = 1'b1;
			end else begin
				res.data = list_words[pos];
				if (kind == KIND_REMOVE) begin
					for (int i = pos; i + 1 < list_len; i++)
						list_words[i] = list_words[i + 1];
					list_len--;
				end
			end
		end
		default: begin
			res.error = 1'b1;
		end
		endcase
		res.count = list_len[CNT_W-1:0];
		res.empty = (list_len == 0);
		res.full  = (list_len == CAPACITY);
		return res;
	endfunction

	task automatic send_op(input logic [KIND_W-1:0] kind, input int pos,
			input logic [DIN_W-1:0] din);
		int gap;
		list_result_t res;
		gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(S_TDATA_W - DIN_W - POS_W){1'b0}}, din, pos[POS_W-1:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		res = apply_list_op(kind, pos, din);
		result_q.push_back(res);
		if (res.error) begin
			n_refused++;
		end else begin
			case (kind)
			KIND_INSERT: n_insert++;
			KIND_READ:   n_read++;
			default:     n_remove++;
			endcase
		end
		if (res.full)
			n_full_seen++;
		if (res.empty)
			n_empty_seen++;
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (result_q.size() != 0);
	endtask

	task automatic send_random_op();
		int roll;
		roll = $urandom_range(0, 99);
		if (list_len == CAPACITY)
			grow = 1'b0;
		else if (list_len == 0)
			grow = 1'b1;
		if (roll < 5)
			send_op(KIND_W'($urandom_range(0, 3)), $urandom_range(0, CAPACITY), $urandom());
		else if (list_len == 0 || roll < (grow ? 60 : 25))
			send_op(KIND_INSERT, $urandom_range(0, list_len), $urandom());
		else if (roll < (grow ? 70 : 45))
			send_op(KIND_READ, $urandom_range(0, list_len - 1), $urandom());
		else
			send_op(KIND_REMOVE, $urandom_range(0, list_len - 1), $urandom());
	endtask

	task automatic check_field(input string name, input logic [DOUT_W-1:0] want,
			input logic [DOUT_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		list_result_t got;
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = list_result_t'(m_tdata);
			if (result_q.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with nothing expected, expected none, got %h",
					$time, m_tdata);
			end else begin
				want = result_q.pop_front();
				n_checked++;
				check_field("data_out", want.data, got.data);
				check_field("count", DOUT_W'(want.count), DOUT_W'(got.count));
				check_field("empty_res", DOUT_W'(want.empty), DOUT_W'(got.empty));
				check_field("full_res", DOUT_W'(want.full), DOUT_W'(got.full));
				check_field("error", DOUT_W'(want.error), DOUT_W'(got.error));
			end
		end
	end

	always @(posedge clk) begin
		if (rx_wait > 0) begin
			rx_wait  <= rx_wait - 1;
			m_tready <= 1'b0;
		end else if (rx_long_req) begin
			rx_long_req <= 1'b0;
			rx_wait     <= LONG_HOLD - 1;
			m_tready    <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			rx_wait  <= $urandom_range(0, 16);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
			$display("positional_list_store_core: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic test_directed();
		send_op(KIND_READ, 0, '0);
		send_op(KIND_REMOVE, 0, '0);
		send_op(KIND_UNUSED, 0, '1);
		send_op(KIND_INSERT, 1, 32'h0000_1234);
		send_op(KIND_INSERT, 0, 32'h0000_0000);
		send_op(KIND_INSERT, 1, 32'hFFFF_FFFF);
		send_op(KIND_INSERT, 0, 32'hA5A5_5A5A);
		send_op(KIND_INSERT, 2, 32'h5A5A_A5A5);
		send_op(KIND_INSERT, 5, $urandom());
		send_op(KIND_READ, 0, '1);
		send_op(KIND_READ, 3, '0);
		send_op(KIND_READ, 4, '0);
		send_op(KIND_READ, 16, '0);
		send_op(KIND_REMOVE, 16, '0);
		send_op(KIND_UNUSED, 16, $urandom());
		send_op(KIND_REMOVE, 1, '0);
		send_op(KIND_REMOVE, 2, '0);
		send_op(KIND_REMOVE, 0, '0);
		send_op(KIND_REMOVE, 0, '0);
		send_op(KIND_INSERT, 16, '1);
	endtask

	task automatic test_full_list();
		while (list_len < CAPACITY)
			send_op(KIND_INSERT, $urandom_range(0, list_len), $urandom());
		send_op(KIND_INSERT, 16, $urandom());
		send_op(KIND_INSERT, 0, $urandom());
		send_op(KIND_READ, 15, '0);
		send_op(KIND_READ, 16, '0);
		send_op(KIND_REMOVE, 15, '0);
		send_op(KIND_INSERT, 15, '1);
		while (list_len > 0)
			send_op(KIND_REMOVE, $urandom_range(0, list_len - 1), $urandom());
	endtask

	task automatic test_queue_stack();
		int depth;
		repeat (4) begin
			depth = $urandom_range(1, CAPACITY);
			repeat (depth) send_op(KIND_INSERT, list_len, $urandom());
			repeat (depth) send_op(KIND_REMOVE, 0, $urandom());
			depth = $urandom_range(1, CAPACITY);
			repeat (depth) send_op(KIND_INSERT, list_len, $urandom());
			repeat (depth) send_op(KIND_REMOVE, list_len - 1, $urandom());
		end
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		rx_long_req = 1'b1;
		repeat (24) send_random_op();
		wait_drain();
		idle_on = 1'b1;
	endtask

	task automatic test_random(input int n_ops);
		repeat (n_ops) send_random_op();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_list();
		test_queue_stack();
		test_backpressure();
		test_random(800);
		idle_on = 1'b0;
		test_random(150);
		wait_drain();
		repeat (10) @(posedge clk);
		if (result_q.size() != 0) begin
			mismatches += result_q.size();
			$display("%0t: %0d results expected, none received", $time, result_q.size());
		end
		$display("Checked %0d results: %0d inserts, %0d reads, %0d removes, %0d refused.",
			n_checked, n_insert, n_read, n_remove, n_refused);
		$display("The list stood full after %0d operations and empty after %0d.",
			n_full_seen, n_empty_seen);
		if (mismatches == 0) begin
			$display("positional_list_store_core: match");
		end else begin
			$display("positional_list_store_core: mismatch");
		end
		$finish;
	end

endmodule
